### hw/rtl/ppts_pkg.sv
package ppts_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned MAX_POINTS_DEF = 1024;

  localparam int unsigned PC_W   = 11;
  localparam int unsigned STEP_W = 31;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MA_W  = 34;
  localparam int unsigned MB_W  = 33;
  localparam int unsigned MUL_W = 50;
  localparam int unsigned NUM_W = MUL_W + 1;
  localparam int unsigned DEN_W = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SQ     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TWO     = 2'd2;

  localparam logic [PC_W-1:0]   PC_RESET  = 11'd1024;
  localparam logic [STEP_W-1:0] GSQ_RESET = 31'd65536;
  localparam logic [STEP_W-1:0] INV_RESET = 31'd32768;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NO_SOLVE = 2'd2;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [MUL_W:0] v);
    logic signed [DATA_W-1:0] r;
    if ((&v[MUL_W:DATA_W-1]) || !(|v[MUL_W:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[MUL_W]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hw/rtl/ppts_mul.sv
module ppts_mul (
  input  logic                             clk_i,
  input  logic signed [ppts_pkg::MA_W-1:0] a_i,
  input  logic signed [ppts_pkg::MB_W-1:0] b_i,
  output logic signed [ppts_pkg::MUL_W-1:0] res_o
);

  localparam int unsigned PW = ppts_pkg::MA_W + ppts_pkg::MB_W;

  logic [ppts_pkg::MA_W-1:0] amag;
  logic [ppts_pkg::MB_W-1:0] bmag;
  logic [PW-1:0]             prod_q;
  logic                      neg_q;
  logic [PW:0]               rnd;
  logic [ppts_pkg::MUL_W-1:0] mag;

  assign amag = a_i[ppts_pkg::MA_W-1] ? ppts_pkg::MA_W'(-a_i) : ppts_pkg::MA_W'(a_i);
  assign bmag = b_i[ppts_pkg::MB_W-1] ? ppts_pkg::MB_W'(-b_i) : ppts_pkg::MB_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(amag) * PW'(bmag);
    neg_q  <= a_i[ppts_pkg::MA_W-1] ^ b_i[ppts_pkg::MB_W-1];
  end

  assign rnd   = (PW+1)'(prod_q) + ((PW+1)'(1) << (ppts_pkg::FRAC_BITS - 1));
  assign mag   = ppts_pkg::MUL_W'(rnd >> ppts_pkg::FRAC_BITS);
  assign res_o = neg_q ? -$signed(mag) : $signed(mag);

endmodule

### hw/rtl/ppts_div.sv
module ppts_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ppts_pkg::NUM_W-1:0] num_i,
  input  logic signed [ppts_pkg::DEN_W-1:0] den_i,
  output logic                              done_o,
  output logic signed [ppts_pkg::DATA_W-1:0] quo_o
);

  localparam int unsigned NMW = 34;
  localparam int unsigned DMW = ppts_pkg::DEN_W;
  localparam int unsigned QW  = NMW + ppts_pkg::FRAC_BITS + 1;
  localparam int unsigned CW  = $clog2(QW + 1);

  logic [ppts_pkg::NUM_W-1:0] nabs;
  logic [NMW-1:0]             nm;
  logic [DMW-1:0]             dm;
  logic [QW-1:0]              dvd;
  logic [DMW-1:0]             dm_q;
  logic [DMW-1:0]             rem_q;
  logic [QW-1:0]              quo_q;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic                       neg_q;
  logic [DMW:0]               trial;
  logic                       take;

  assign nabs = num_i[ppts_pkg::NUM_W-1] ? ppts_pkg::NUM_W'(-num_i)
                                         : ppts_pkg::NUM_W'(num_i);
  assign nm   = (nabs > (ppts_pkg::NUM_W'(1) << 33)) ? (NMW'(1) << 33) : NMW'(nabs);
  assign dm   = den_i[DMW-1] ? DMW'(-den_i) : DMW'(den_i);
  assign dvd  = (QW'(nm) << ppts_pkg::FRAC_BITS) + QW'(dm >> 1);

  assign trial = {rem_q, quo_q[QW-1]};
  assign take  = trial >= {1'b0, dm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dvd;
      dm_q  <= dm;
      neg_q <= num_i[ppts_pkg::NUM_W-1] ^ den_i[DMW-1];
    end else if (busy_q) begin
      rem_q <= take ? DMW'(trial - {1'b0, dm_q}) : DMW'(trial);
      quo_q <= {quo_q[QW-2:0], take};
    end
  end

  always_comb begin
    if (dm_q == '0) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (quo_q > (QW'(1) << 31)) ? {1'b1, 31'd0} : -$signed(quo_q[31:0]);
    end else begin
      quo_o = (quo_q > QW'(32'h7fffffff)) ? {1'b0, {31{1'b1}}} : $signed(quo_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

### hw/rtl/periodic_poisson_tridiagonal_solver_unit.sv
// channel | signals                                   | direction
// input   | in_valid_i, in_stall_o, op_i, charge_i,   | into block
//         | index_i                                   |
// output  | out_valid_o, out_stall_i, potential_o,    | out of block
//         | field_o, status_o                         |
// config  | cfg_we_i, cfg_idx_i, cfg_data_i           | into block
// A load word goes straight to the charge store; a read word sets its result register
// directly on an error, else through S_RD. The last load of a frame starts the solve:
// each forward row reads, multiplies and takes two passes of the shared divider (one
// for the last row), then back-substitution rows, end-point zeroing and field points.
// Reset clears control and config; the stores are not cleared.
// Input stalls while solving or reading, while a result waits, and in the end-point copy cycle.
module periodic_poisson_tridiagonal_solver_unit #(
  parameter int unsigned MAX_POINTS = ppts_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  op_i,
  input  logic signed [ppts_pkg::DATA_W-1:0]    charge_i,
  input  logic [ppts_pkg::IDX_W-1:0]            index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [ppts_pkg::DATA_W-1:0]    potential_o,
  output logic signed [ppts_pkg::DATA_W-1:0]    field_o,
  output logic [1:0]                            status_o,
  input  logic                                  cfg_we_i,
  input  logic [ppts_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ppts_pkg::STEP_W-1:0]           cfg_data_i
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned NW  = (CW > ppts_pkg::PC_W) ? CW : ppts_pkg::PC_W;
  localparam int unsigned DW  = ppts_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_FRD, S_FMUL, S_FWAIT, S_DIV1, S_DIV2,
    S_BRD, S_BMUL, S_BWAIT, S_Z0, S_Z1, S_EA, S_EB, S_EMUL, S_EWAIT
  } state_e;

  state_e state_q;

  logic [ppts_pkg::PC_W-1:0]   pc_q;
  logic [ppts_pkg::STEP_W-1:0] gsq_q;
  logic [ppts_pkg::STEP_W-1:0] inv_q;
  logic [CW-1:0]               load_q;
  logic                        ready_q;
  logic [AW-1:0]               row_q;
  logic signed [DW-1:0]        r_q, o_q, onew_q, p_q, a_q, f0_q;
  logic                        out_valid_q;
  logic signed [DW-1:0]        pot_out_q, fld_out_q;
  logic [1:0]                  status_q;

  logic signed [DW-1:0] charge_mem [MAX_POINTS];
  logic signed [DW-1:0] ratio_mem  [MAX_POINTS];
  logic signed [DW-1:0] offset_mem [MAX_POINTS];
  logic signed [DW-1:0] pot_mem    [MAX_POINTS];
  logic signed [DW-1:0] fld_mem    [MAX_POINTS];
  logic signed [DW-1:0] charge_rd_q, ratio_rd_q, offset_rd_q, pot_rd_q, fld_rd_q;

  logic [NW-1:0]  n_full;
  logic [AW-1:0]  nm1, nm2, im, ip;
  logic           in_acc;
  logic           load_last;
  logic [AW-1:0]  pot_raddr;
  logic           pot_we;
  logic [AW-1:0]  pot_waddr;
  logic signed [DW-1:0] pot_wdata;
  logic           fld_we;
  logic [AW-1:0]  fld_waddr;
  logic signed [DW-1:0] fld_wdata;

  logic signed [ppts_pkg::MA_W-1:0]  mul_a;
  logic signed [ppts_pkg::MB_W-1:0]  mul_b;
  logic signed [ppts_pkg::MUL_W-1:0] mul_res;
  logic                              div_start;
  logic signed [ppts_pkg::NUM_W-1:0] div_num;
  logic signed [ppts_pkg::DEN_W-1:0] div_den;
  logic                              div_done;
  logic signed [DW-1:0]              div_quo;
  logic signed [ppts_pkg::MUL_W:0]   back_sum, fld_neg;
  logic signed [DW-1:0]              back_v, fld_v;

  always_comb begin
    if (NW'(pc_q) < NW'(4)) begin
      n_full = NW'(4);
    end else if (NW'(pc_q) > NW'(MAX_POINTS)) begin
      n_full = NW'(MAX_POINTS);
    end else begin
      n_full = NW'(pc_q);
    end
  end

  assign nm1       = AW'(n_full - NW'(1));
  assign nm2       = AW'(n_full - NW'(2));
  assign im        = (row_q == '0) ? nm2 : row_q - 1'b1;
  assign ip        = (row_q == nm2) ? '0 : row_q + 1'b1;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q || (ready_q && (row_q == nm1));
  assign in_acc    = in_valid_i && !in_stall_o;
  assign load_last = (NW'(load_q) + NW'(1)) >= n_full;

  always_comb begin
    case (state_q)
      S_EA:    pot_raddr = im;
      S_EB:    pot_raddr = ip;
      default: pot_raddr = AW'(index_i);
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_FMUL: begin
        mul_a = ppts_pkg::MA_W'(charge_rd_q);
        mul_b = $signed(ppts_pkg::MB_W'(gsq_q));
      end
      S_BMUL: begin
        mul_a = ppts_pkg::MA_W'(ratio_rd_q);
        mul_b = ppts_pkg::MB_W'(p_q);
      end
      S_EMUL: begin
        mul_a = ppts_pkg::MA_W'(pot_rd_q) - ppts_pkg::MA_W'(a_q);
        mul_b = $signed(ppts_pkg::MB_W'(inv_q));
      end
      default: ;
    endcase
  end

  ppts_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  assign div_den = ppts_pkg::DEN_W'(r_q) - (ppts_pkg::DEN_W'(2) << ppts_pkg::FRAC_BITS);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    case (state_q)
      S_FWAIT: begin
        div_start = 1'b1;
        div_num   = -ppts_pkg::NUM_W'(mul_res) - ppts_pkg::NUM_W'(o_q);
      end
      S_DIV1: begin
        div_start = div_done && (row_q != nm2);
        div_num   = -(ppts_pkg::NUM_W'(1) << ppts_pkg::FRAC_BITS);
      end
      default: ;
    endcase
  end

  ppts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign back_sum = (ppts_pkg::MUL_W+1)'(mul_res) + (ppts_pkg::MUL_W+1)'(offset_rd_q);
  assign back_v   = ppts_pkg::sat32(back_sum);
  assign fld_neg  = -(ppts_pkg::MUL_W+1)'(mul_res);
  assign fld_v    = ppts_pkg::sat32(fld_neg);

  always_comb begin
    pot_we    = 1'b0;
    pot_waddr = row_q;
    pot_wdata = div_quo;
    fld_we    = 1'b0;
    fld_waddr = row_q;
    fld_wdata = fld_v;
    case (state_q)
      S_DIV1: pot_we = div_done && (row_q == nm2);
      S_BWAIT: begin
        pot_we    = 1'b1;
        pot_waddr = row_q - 1'b1;
        pot_wdata = back_v;
      end
      S_Z0: begin
        pot_we    = 1'b1;
        pot_waddr = '0;
        pot_wdata = '0;
      end
      S_Z1: begin
        pot_we    = 1'b1;
        pot_waddr = nm1;
        pot_wdata = '0;
      end
      S_EWAIT: fld_we = 1'b1;
      S_IDLE: begin
        fld_we    = ready_q && (row_q == nm1);
        fld_wdata = f0_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (op_i == ppts_pkg::OP_LOAD)) begin
      charge_mem[AW'(load_q)] <= charge_i;
    end
    if (state_q == S_DIV2 && div_done) begin
      ratio_mem[row_q + 1'b1]  <= div_quo;
      offset_mem[row_q + 1'b1] <= onew_q;
    end
    if (pot_we) begin
      pot_mem[pot_waddr] <= pot_wdata;
    end
    if (fld_we) begin
      fld_mem[fld_waddr] <= fld_wdata;
    end
    charge_rd_q <= charge_mem[row_q];
    ratio_rd_q  <= ratio_mem[row_q];
    offset_rd_q <= offset_mem[row_q];
    pot_rd_q    <= pot_mem[pot_raddr];
    fld_rd_q    <= fld_mem[AW'(index_i)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= ppts_pkg::PC_RESET;
      gsq_q       <= ppts_pkg::GSQ_RESET;
      inv_q       <= ppts_pkg::INV_RESET;
      load_q      <= '0;
      ready_q     <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ppts_pkg::ST_OK;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ppts_pkg::CFG_POINT_COUNT: begin
            pc_q    <= cfg_data_i[ppts_pkg::PC_W-1:0];
            load_q  <= '0;
            ready_q <= 1'b0;
          end
          ppts_pkg::CFG_STEP_SQ: gsq_q <= cfg_data_i;
          ppts_pkg::CFG_INV_TWO: inv_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (ready_q && row_q == nm1) begin
            row_q <= '0;
          end
          if (in_acc) begin
            if (op_i == ppts_pkg::OP_LOAD) begin
              if (load_last) begin
                load_q  <= '0;
                ready_q <= 1'b0;
                row_q   <= AW'(1);
                r_q     <= '0;
                o_q     <= '0;
                state_q <= S_FRD;
              end else begin
                load_q <= load_q + 1'b1;
              end
            end else if (!ready_q) begin
              status_q    <= ppts_pkg::ST_NO_SOLVE;
              pot_out_q   <= '0;
              fld_out_q   <= '0;
              out_valid_q <= 1'b1;
            end else if (NW'(index_i) >= n_full) begin
              status_q    <= ppts_pkg::ST_RANGE;
              pot_out_q   <= '0;
              fld_out_q   <= '0;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          status_q    <= ppts_pkg::ST_OK;
          pot_out_q   <= pot_rd_q;
          fld_out_q   <= fld_rd_q;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_FRD:   state_q <= S_FMUL;
        S_FMUL:  state_q <= S_FWAIT;
        S_FWAIT: state_q <= S_DIV1;
        S_DIV1: begin
          if (div_done) begin
            onew_q <= div_quo;
            if (row_q == nm2) begin
              p_q     <= div_quo;
              state_q <= S_BRD;
            end else begin
              state_q <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          if (div_done) begin
            r_q     <= div_quo;
            o_q     <= onew_q;
            row_q   <= row_q + 1'b1;
            state_q <= S_FRD;
          end
        end
        S_BRD: state_q <= (row_q < AW'(2)) ? S_Z0 : S_BMUL;
        S_BMUL: state_q <= S_BWAIT;
        S_BWAIT: begin
          p_q     <= back_v;
          row_q   <= row_q - 1'b1;
          state_q <= (row_q == AW'(2)) ? S_Z0 : S_BRD;
        end
        S_Z0: state_q <= S_Z1;
        S_Z1: begin
          row_q   <= '0;
          state_q <= S_EA;
        end
        S_EA: state_q <= S_EB;
        S_EB: begin
          a_q     <= pot_rd_q;
          state_q <= S_EMUL;
        end
        S_EMUL: state_q <= S_EWAIT;
        S_EWAIT: begin
          if (row_q == '0) begin
            f0_q <= fld_v;
          end
          if (row_q == nm2) begin
            row_q   <= nm1;
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= S_EA;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign potential_o = pot_out_q;
  assign field_o     = fld_out_q;
  assign status_o    = status_q;

endmodule

### hw/rtl/ppts_checker.sv
module ppts_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               op_i,
  input logic signed [ppts_pkg::DATA_W-1:0] charge_i,
  input logic [ppts_pkg::IDX_W-1:0]         index_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [ppts_pkg::DATA_W-1:0] potential_o,
  input logic signed [ppts_pkg::DATA_W-1:0] field_o,
  input logic [1:0]                         status_o,
  input logic                               cfg_we_i,
  input logic [ppts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input logic [ppts_pkg::STEP_W-1:0]        cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(potential_o)
      && $stable(field_o) && $stable(status_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ppts_pkg::ST_NO_SOLVE)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ppts_pkg::ST_OK |-> potential_o == '0 && field_o == '0)
    else $error("error result carries data");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == ppts_pkg::OP_LOAD) && !out_valid_o
      |=> !out_valid_o)
    else $error("load produced a result");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

endmodule

bind periodic_poisson_tridiagonal_solver_unit ppts_checker u_ppts_checker (.*);
